// ===== hw/rtl/tls_sni_extractor_macros.svh =====
// assertion helpers used by the tls sni extractor output fifo
`ifndef TLS_SNI_EXTRACTOR_MACROS_SVH
`define TLS_SNI_EXTRACTOR_MACROS_SVH

// same-cycle implication, checked on aclk and held off during reset
`define TSE_ASSERT_IMPL(name, ante, cons) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("tse check failed");

// next-cycle implication, checked on aclk and held off during reset
`define TSE_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("tse check failed");

`endif

// ===== hw/rtl/tse_pkg.sv =====
`timescale 1ns / 1ps

package tse_pkg;

    localparam int SCAN_LIMIT_DEFAULT = 4096;
    localparam int FIFO_DEPTH_DEFAULT = 8;

    localparam logic [15:0] TLS_PORT = 16'd443;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_FAIL = 2'd1;
    localparam logic [1:0] ST_MORE = 2'd2;

    localparam logic KIND_NAME   = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    typedef struct packed {
        logic [15:0] dest_port;
        logic        last_byte;
        logic        first_byte;
        logic [7:0]  data_byte;
    } in_item_t;

    typedef struct packed {
        logic        item_kind;
        logic [7:0]  name_byte;
        logic [1:0]  status;
        logic        odd_port;
        logic [15:0] server_port;
        logic        end_of_run;
    } result_t;

    // up to two results per input byte, r0 first
    typedef struct packed {
        logic [1:0] cnt;
        result_t    r0;
        result_t    r1;
    } res_push_t;

endpackage

// ===== hw/rtl/tse_parser.sv =====
`timescale 1ns / 1ps

module tse_parser #(
    parameter int SCAN_LIMIT = tse_pkg::SCAN_LIMIT_DEFAULT
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    input  tse_pkg::in_item_t   in_item,
    output tse_pkg::res_push_t  push
);

    localparam int BW = $clog2(SCAN_LIMIT + 1);

    localparam logic [4:0] PH_IDLE  = 5'd0;
    localparam logic [4:0] PH_R0    = 5'd1;
    localparam logic [4:0] PH_R1    = 5'd2;
    localparam logic [4:0] PH_R2    = 5'd3;
    localparam logic [4:0] PH_R3    = 5'd4;
    localparam logic [4:0] PH_R4    = 5'd5;
    localparam logic [4:0] PH_HT    = 5'd6;
    localparam logic [4:0] PH_HL0   = 5'd7;
    localparam logic [4:0] PH_HL1   = 5'd8;
    localparam logic [4:0] PH_HL2   = 5'd9;
    localparam logic [4:0] PH_VMAJ  = 5'd10;
    localparam logic [4:0] PH_VMIN  = 5'd11;
    localparam logic [4:0] PH_SKIP  = 5'd12;
    localparam logic [4:0] PH_SID   = 5'd13;
    localparam logic [4:0] PH_CS0   = 5'd14;
    localparam logic [4:0] PH_CS1   = 5'd15;
    localparam logic [4:0] PH_COMP  = 5'd16;
    localparam logic [4:0] PH_EL0   = 5'd17;
    localparam logic [4:0] PH_EL1   = 5'd18;
    localparam logic [4:0] PH_ET0   = 5'd19;
    localparam logic [4:0] PH_ET1   = 5'd20;
    localparam logic [4:0] PH_EX0   = 5'd21;
    localparam logic [4:0] PH_EX1   = 5'd22;
    localparam logic [4:0] PH_SN0   = 5'd23;
    localparam logic [4:0] PH_SN1   = 5'd24;
    localparam logic [4:0] PH_STYPE = 5'd25;
    localparam logic [4:0] PH_NL0   = 5'd26;
    localparam logic [4:0] PH_NL1   = 5'd27;
    localparam logic [4:0] PH_NAME  = 5'd28;
    localparam logic [4:0] PH_HOLD  = 5'd29;
    localparam logic [4:0] PH_HMORE = 5'd30;
    localparam logic [4:0] PH_STUCK = 5'd31;

    logic [4:0]    phase_reg, phase_next;
    logic [BW-1:0] seen_reg, seen_next;
    logic [15:0]   fcnt_reg, fcnt_next;
    logic [15:0]   rlen_reg, rlen_next;
    logic [23:0]   hrem_reg, hrem_next;
    logic [15:0]   erem_reg, erem_next;
    logic [15:0]   elen_reg, elen_next;
    logic [15:0]   nleft_reg, nleft_next;
    logic [15:0]   port_reg, port_next;
    logic          found_reg, found_next;
    logic          decided_reg, decided_next;
    logic          hbad_reg, hbad_next;
    logic [4:0]    resume_reg, resume_next;

    logic [7:0]  b;
    logic        name_v;
    logic        stat_v;
    logic [1:0]  stat_code;
    logic        do_ext;
    logic [15:0] ext_used;
    logic        do_skip;
    logic [15:0] skip_cnt;
    logic [4:0]  skip_to;
    logic [15:0] xlen;
    tse_pkg::result_t name_res;
    tse_pkg::result_t stat_res;

    // field entry that falls back to need-more when the hello has no room
    function automatic logic [4:0] enter_ph(input logic [4:0] ph, input logic [23:0] hrem);
        logic [1:0] need;
        need = (ph == PH_CS0 || ph == PH_EL0) ? 2'd2 : ((ph == PH_COMP) ? 2'd1 : 2'd0);
        return (hrem < 24'(need)) ? PH_HMORE : ph;
    endfunction

    assign b = in_item.data_byte;

    always_comb begin
        phase_next   = phase_reg;
        seen_next    = seen_reg;
        fcnt_next    = fcnt_reg;
        rlen_next    = rlen_reg;
        hrem_next    = hrem_reg;
        erem_next    = erem_reg;
        elen_next    = elen_reg;
        nleft_next   = nleft_reg;
        port_next    = port_reg;
        found_next   = found_reg;
        decided_next = decided_reg;
        hbad_next    = hbad_reg;
        resume_next  = resume_reg;
        name_v       = 1'b0;
        stat_v       = 1'b0;
        stat_code    = tse_pkg::ST_OK;
        do_ext       = 1'b0;
        ext_used     = '0;
        do_skip      = 1'b0;
        skip_cnt     = '0;
        skip_to      = PH_IDLE;
        xlen         = '0;

        if (in_valid) begin
            if (in_item.first_byte) begin
                phase_next   = PH_R0;
                seen_next    = '0;
                fcnt_next    = '0;
                rlen_next    = '0;
                hrem_next    = '0;
                erem_next    = '0;
                elen_next    = '0;
                nleft_next   = '0;
                port_next    = in_item.dest_port;
                found_next   = 1'b0;
                decided_next = 1'b0;
                hbad_next    = 1'b0;
                resume_next  = PH_IDLE;
            end

            if (phase_next != PH_IDLE && !decided_next) begin
                if (seen_next < BW'(SCAN_LIMIT)) begin
                    seen_next = seen_next + 1'b1;
                end

                case (phase_next)
                    PH_R0: begin
                        hbad_next  = (b != 8'd22);
                        phase_next = PH_R1;
                    end
                    PH_R1: begin
                        if (b != 8'd3) hbad_next = 1'b1;
                        phase_next = PH_R2;
                    end
                    PH_R2: begin
                        if (b < 8'd1 || b > 8'd3) hbad_next = 1'b1;
                        phase_next = PH_R3;
                    end
                    PH_R3: begin
                        rlen_next  = {b, 8'd0};
                        phase_next = PH_R4;
                    end
                    PH_R4: begin
                        rlen_next = {rlen_next[15:8], b};
                        if (hbad_next) begin
                            stat_v       = 1'b1;
                            stat_code    = tse_pkg::ST_FAIL;
                            decided_next = 1'b1;
                        end else if (rlen_next == 16'd0) begin
                            phase_next = PH_STUCK;
                        end else if (rlen_next < 16'd4) begin
                            phase_next = PH_HMORE;
                        end else begin
                            phase_next = PH_HT;
                        end
                    end
                    PH_STUCK: begin
                    end
                    default: begin
                        if (rlen_next != 16'd0) rlen_next = rlen_next - 1'b1;

                        case (phase_next)
                            PH_HT: begin
                                fcnt_next  = {8'd0, b};
                                phase_next = PH_HL0;
                            end
                            PH_HL0: begin
                                hrem_next  = {b, 16'd0};
                                phase_next = PH_HL1;
                            end
                            PH_HL1: begin
                                hrem_next  = hrem_next | {8'd0, b, 8'd0};
                                phase_next = PH_HL2;
                            end
                            PH_HL2: begin
                                hrem_next = hrem_next | {16'd0, b};
                                if (hrem_next > {8'd0, rlen_next}) phase_next = PH_HMORE;
                                else if (fcnt_next != 16'd1) phase_next = PH_HOLD;
                                else phase_next = PH_VMAJ;
                            end
                            PH_VMAJ: begin
                                fcnt_next  = (b == 8'd3) ? 16'd1 : 16'd0;
                                phase_next = PH_VMIN;
                            end
                            PH_VMIN: begin
                                if (fcnt_next == 16'd0 || b < 8'd1 || b > 8'd3) begin
                                    phase_next = PH_HOLD;
                                end else if (hrem_next < 24'd35) begin
                                    phase_next = PH_HMORE;
                                end else begin
                                    // random is skipped as a 32 byte run
                                    hrem_next = hrem_next - 24'd34;
                                    do_skip   = 1'b1;
                                    skip_cnt  = 16'd32;
                                    skip_to   = PH_SID;
                                end
                            end
                            PH_SKIP: begin
                                fcnt_next = fcnt_next - 1'b1;
                                if (fcnt_next == 16'd0) begin
                                    phase_next = enter_ph(resume_next, hrem_next);
                                end
                            end
                            PH_SID, PH_COMP: begin
                                if ({1'b0, hrem_next} < 25'(b) + 25'd1) begin
                                    phase_next = PH_HMORE;
                                end else begin
                                    hrem_next = hrem_next - 24'(b) - 24'd1;
                                    do_skip   = 1'b1;
                                    skip_cnt  = {8'd0, b};
                                    skip_to   = (phase_next == PH_SID) ? PH_CS0 : PH_EL0;
                                end
                            end
                            PH_CS0, PH_EL0: begin
                                fcnt_next  = {b, 8'd0};
                                phase_next = (phase_next == PH_CS0) ? PH_CS1 : PH_EL1;
                            end
                            PH_CS1: begin
                                xlen = fcnt_next | {8'd0, b};
                                if ({1'b0, hrem_next} < 25'(xlen) + 25'd2) begin
                                    phase_next = PH_HMORE;
                                end else begin
                                    hrem_next = hrem_next - 24'(xlen) - 24'd2;
                                    do_skip   = 1'b1;
                                    skip_cnt  = xlen;
                                    skip_to   = PH_COMP;
                                end
                            end
                            PH_EL1: begin
                                xlen = fcnt_next | {8'd0, b};
                                if ({1'b0, hrem_next} < 25'(xlen) + 25'd2) begin
                                    phase_next = PH_HMORE;
                                end else begin
                                    erem_next  = xlen;
                                    phase_next = (xlen > 16'd4) ? PH_ET0 : PH_HOLD;
                                end
                            end
                            PH_ET0, PH_SN0: begin
                                fcnt_next  = {b, 8'd0};
                                phase_next = (phase_next == PH_ET0) ? PH_ET1 : PH_SN1;
                            end
                            PH_ET1: begin
                                fcnt_next  = fcnt_next | {8'd0, b};
                                phase_next = PH_EX0;
                            end
                            PH_EX0: begin
                                elen_next  = {b, 8'd0};
                                phase_next = PH_EX1;
                            end
                            PH_EX1: begin
                                elen_next = elen_next | {8'd0, b};
                                if (fcnt_next == 16'd0 && elen_next >= 16'd5 &&
                                    17'(elen_next) + 17'd4 <= 17'(erem_next)) begin
                                    phase_next = PH_SN0;
                                end else begin
                                    do_ext   = 1'b1;
                                    ext_used = 16'd0;
                                end
                            end
                            PH_SN1: begin
                                fcnt_next = fcnt_next | {8'd0, b};
                                if (fcnt_next != elen_next - 16'd2) begin
                                    do_ext   = 1'b1;
                                    ext_used = 16'd2;
                                end else begin
                                    phase_next = PH_STYPE;
                                end
                            end
                            PH_STYPE: begin
                                if (b != 8'd0) begin
                                    do_ext   = 1'b1;
                                    ext_used = 16'd3;
                                end else begin
                                    phase_next = PH_NL0;
                                end
                            end
                            PH_NL0: begin
                                nleft_next = {b, 8'd0};
                                phase_next = PH_NL1;
                            end
                            PH_NL1: begin
                                nleft_next = nleft_next | {8'd0, b};
                                if (nleft_next != elen_next - 16'd5) begin
                                    do_ext   = 1'b1;
                                    ext_used = 16'd5;
                                end else if (nleft_next == 16'd0) begin
                                    found_next = 1'b1;
                                    phase_next = PH_HOLD;
                                end else begin
                                    phase_next = PH_NAME;
                                end
                            end
                            PH_NAME: begin
                                name_v     = 1'b1;
                                nleft_next = nleft_next - 1'b1;
                                if (nleft_next == 16'd0) begin
                                    found_next = 1'b1;
                                    phase_next = PH_HOLD;
                                end
                            end
                            default: begin
                            end
                        endcase

                        // move past the rest of an extension that is not a usable name
                        if (do_ext) begin
                            if ({2'd0, erem_next} <= 18'(elen_next) + 18'd8) begin
                                phase_next = PH_HOLD;
                            end else begin
                                erem_next = erem_next - elen_next - 16'd4;
                                do_skip   = 1'b1;
                                skip_cnt  = elen_next - ext_used;
                                skip_to   = PH_ET0;
                            end
                        end

                        if (do_skip) begin
                            if (skip_cnt == 16'd0) begin
                                phase_next = enter_ph(skip_to, hrem_next);
                            end else begin
                                fcnt_next   = skip_cnt;
                                resume_next = skip_to;
                                phase_next  = PH_SKIP;
                            end
                        end

                        // record fully in: settle the outcome
                        if (rlen_next == 16'd0) begin
                            if (phase_next == PH_HOLD) begin
                                stat_v       = 1'b1;
                                stat_code    = found_next ? tse_pkg::ST_OK : tse_pkg::ST_FAIL;
                                decided_next = 1'b1;
                            end else if (phase_next == PH_HMORE) begin
                                phase_next = PH_STUCK;
                            end else begin
                                stat_v       = 1'b1;
                                stat_code    = tse_pkg::ST_FAIL;
                                decided_next = 1'b1;
                            end
                        end
                    end
                endcase

                if (!decided_next && in_item.last_byte) begin
                    stat_v = 1'b1;
                    if (seen_next >= BW'(SCAN_LIMIT)) begin
                        stat_code    = tse_pkg::ST_FAIL;
                        decided_next = 1'b1;
                    end else begin
                        stat_code = tse_pkg::ST_MORE;
                    end
                end
            end
        end
    end

    always_comb begin
        name_res             = '0;
        name_res.item_kind   = tse_pkg::KIND_NAME;
        name_res.name_byte   = b;
        name_res.end_of_run  = !stat_v;

        stat_res             = '0;
        stat_res.item_kind   = tse_pkg::KIND_STATUS;
        stat_res.status      = stat_code;
        stat_res.odd_port    = (port_next != tse_pkg::TLS_PORT);
        stat_res.server_port = port_next;
        stat_res.end_of_run  = 1'b1;

        push.cnt = 2'(name_v) + 2'(stat_v);
        push.r0  = name_v ? name_res : stat_res;
        push.r1  = stat_res;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_IDLE;
            seen_reg    <= '0;
            fcnt_reg    <= '0;
            rlen_reg    <= '0;
            hrem_reg    <= '0;
            erem_reg    <= '0;
            elen_reg    <= '0;
            nleft_reg   <= '0;
            port_reg    <= '0;
            found_reg   <= 1'b0;
            decided_reg <= 1'b0;
            hbad_reg    <= 1'b0;
            resume_reg  <= PH_IDLE;
        end else begin
            phase_reg   <= phase_next;
            seen_reg    <= seen_next;
            fcnt_reg    <= fcnt_next;
            rlen_reg    <= rlen_next;
            hrem_reg    <= hrem_next;
            erem_reg    <= erem_next;
            elen_reg    <= elen_next;
            nleft_reg   <= nleft_next;
            port_reg    <= port_next;
            found_reg   <= found_next;
            decided_reg <= decided_next;
            hbad_reg    <= hbad_next;
            resume_reg  <= resume_next;
        end
    end

endmodule

// ===== hw/rtl/tse_out_fifo.sv =====
`timescale 1ns / 1ps

`include "tls_sni_extractor_macros.svh"

module tse_out_fifo #(
    parameter int DEPTH = tse_pkg::FIFO_DEPTH_DEFAULT
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  tse_pkg::res_push_t         push,
    input  logic                       pop,
    output tse_pkg::result_t           head,
    output logic                       not_empty,
    output logic [$clog2(DEPTH+1)-1:0] count
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    tse_pkg::result_t mem_reg [DEPTH];

    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic [PW-1:0] wr_ptr_1;
    logic [CW:0]   fill_sum;

    function automatic logic [PW-1:0] wrap_inc(input logic [PW-1:0] p);
        return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign wr_ptr_1 = wrap_inc(wr_ptr_reg);

    always_comb begin
        fill_sum    = {1'b0, count_reg} + (CW + 1)'(push.cnt);
        count_next  = CW'(fill_sum - (CW + 1)'(pop));
        rd_ptr_next = pop ? wrap_inc(rd_ptr_reg) : rd_ptr_reg;
        case (push.cnt)
            2'd1:    wr_ptr_next = wr_ptr_1;
            2'd2:    wr_ptr_next = wrap_inc(wr_ptr_1);
            default: wr_ptr_next = wr_ptr_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push.cnt != 2'd0) mem_reg[wr_ptr_reg] <= push.r0;
        if (push.cnt == 2'd2) mem_reg[wr_ptr_1] <= push.r1;
    end

    assign head      = mem_reg[rd_ptr_reg];
    assign not_empty = (count_reg != '0);
    assign count     = count_reg;

    `TSE_ASSERT_IMPL(a_count_bound, 1'b1, count_reg <= CW'(DEPTH))
    `TSE_ASSERT_IMPL(a_no_overflow, push.cnt != 2'd0, fill_sum <= (CW + 1)'(DEPTH))
    `TSE_ASSERT_NEXT(a_drain_step, pop && push.cnt == 2'd0, count_reg == $past(count_reg) - 1'b1)

endmodule

// ===== hw/rtl/tls_sni_extractor.sv =====
`timescale 1ns / 1ps

// Parses TLS ClientHello payload one byte per cycle and streams out the SNI
// host name bytes followed by a status item (ok, fail or need more data). An
// input byte is taken every cycle while s_tready is high; it is registered,
// run through the parser and its zero to two result items are written to an
// output queue of FIFO_DEPTH entries that drains one item per cycle while
// m_tready is high; the input register and the queue lie between accept and m_*.
// s_tready drops only when the queue could not hold the results of the byte
// in flight plus one more, so the sustained rate is one byte per cycle as
// long as results are taken as fast as they are made; s_tlast (last_byte)
// draws a status item while the flow is undecided. No setup pass after reset.
module tls_sni_extractor #(
    parameter int SCAN_LIMIT = tse_pkg::SCAN_LIMIT_DEFAULT,
    parameter int FIFO_DEPTH = tse_pkg::FIFO_DEPTH_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // data_byte, dest_port
    input  logic        s_tuser,   // first_byte
    input  logic        s_tlast,   // last_byte

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // name_byte, status, odd_port, server_port, zero fill
    output logic        m_tuser,   // item_kind
    output logic        m_tlast    // end_of_run
);

    localparam int CW = $clog2(FIFO_DEPTH + 1);

    logic              in_valid_reg;
    tse_pkg::in_item_t in_item_reg;
    tse_pkg::res_push_t push;
    tse_pkg::result_t   head;
    logic              head_valid;
    logic [CW-1:0]     fifo_count;
    logic [CW+1:0]     room_need;
    logic              s_accept;

    // room for the byte already registered and the one being taken now
    assign room_need = (CW + 2)'(fifo_count) + (in_valid_reg ? (CW + 2)'(4) : (CW + 2)'(2));
    assign s_tready  = (room_need <= (CW + 2)'(FIFO_DEPTH));
    assign s_accept  = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= s_accept;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_item_reg.data_byte  <= s_tdata[7:0];
            in_item_reg.dest_port  <= s_tdata[23:8];
            in_item_reg.first_byte <= s_tuser;
            in_item_reg.last_byte  <= s_tlast;
        end
    end

    tse_parser #(
        .SCAN_LIMIT(SCAN_LIMIT)
    ) u_parser (
        .aclk    (aclk),
        .aresetn (aresetn),
        .in_valid(in_valid_reg),
        .in_item (in_item_reg),
        .push    (push)
    );

    tse_out_fifo #(
        .DEPTH(FIFO_DEPTH)
    ) u_out_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .pop      (m_tvalid && m_tready),
        .head     (head),
        .not_empty(head_valid),
        .count    (fifo_count)
    );

    assign m_tvalid = head_valid;
    assign m_tdata  = {5'd0, head.server_port, head.odd_port, head.status, head.name_byte};
    assign m_tuser  = head.item_kind;
    assign m_tlast  = head.end_of_run;

endmodule
